### rtl/rau_pkg.sv
// Package for the rational arithmetic unit: payload structs, operation codes
// and word width constant. No dependencies.
package rau_pkg;

  localparam int WordBits = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] a_whole;
    logic signed [31:0] a_numerator;
    logic signed [31:0] a_denominator;
    logic signed [31:0] b_whole;
    logic signed [31:0] b_numerator;
    logic signed [31:0] b_denominator;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_whole;
    logic signed [31:0] res_numerator;
    logic signed [31:0] res_denominator;
    logic               zero_denominator;
  } out_item_t;

endpackage

### rtl/rational_arithmetic_unit_top.sv
// Rational arithmetic unit top level: sequencer, shared multiplier and
// shared restoring divider. Depends on rau_pkg.
//
// Usage: one transaction on the in_ channel carries an operation and two
// mixed numbers (whole, numerator, denominator). The unit makes both operands
// improper, applies add, subtract, multiply or divide, moves the truncated
// quotient into the whole part, folds a numerator equal to the denominator
// into one whole, and reduces the fraction by the Euclidean gcd. One result
// transaction leaves on the out_ channel for each input transaction.
// Arithmetic wraps at WORD_BITS bits, two's complement. A zero result
// denominator raises zero_denominator with all other fields zero.
// Timing: one item at a time. A single multiplier is used for up to six
// products, and a single one-bit-per-cycle restoring divider serves the
// quotient, every gcd remainder step and the two final divides.
// in_stall is high from acceptance until the result moves into the output
// register. A finished result waits while a stalled one still holds the
// output register. Reset returns the sequencer to idle with no result pending.
module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int WORD_BITS = WordBits
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int W = WORD_BITS;
  localparam int CW = $clog2(W + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_TA, S_TB, S_IA, S_P1, S_P2, S_P3, S_CHK, S_QDIV, S_QMUL,
    S_FIX, S_GSTART, S_GDIV, S_GNEXT, S_RN, S_RND, S_RD, S_RDD, S_OUT
  } state_t;

  state_t state_r;
  logic [1:0] op_r;
  logic signed [W-1:0] aw_r, an_r, ad_r, bw_r, bn_r, bd_r;
  logic signed [W-1:0] n_r, d_r, w_r, x_r, p_r, q_r;
  logic signed [W-1:0] mul_a, mul_b, mul_p;
  out_item_t out_r;
  logic out_valid_r;

  // shared divider (unsigned magnitude, restoring, one bit per cycle)
  logic div_go;
  logic signed [W-1:0] div_num, div_den;
  logic [W-1:0] dq_r, drem_r, dd_r;
  logic [CW-1:0] dcnt_r;
  logic dbusy_r, dnq_r, dnr_r, ddone;
  logic [W:0] dtrial;
  logic signed [W-1:0] quo, rem;

  function automatic logic signed [W-1:0] wabs(input logic signed [W-1:0] v);
    return v[W-1] ? -v : v;
  endfunction

  assign mul_p = mul_a * mul_b;
  assign dtrial = {drem_r, dq_r[W-1]} - {1'b0, dd_r};
  assign ddone = dbusy_r && (dcnt_r == '0);
  assign quo = dnq_r ? -$signed(dq_r) : $signed(dq_r);
  assign rem = dnr_r ? -$signed(drem_r) : $signed(drem_r);

  always_comb begin
    mul_a = aw_r;
    mul_b = ad_r;
    div_go = 1'b0;
    div_num = n_r;
    div_den = d_r;
    case (state_r)
      S_TA: begin mul_a = aw_r; mul_b = ad_r; end
      S_TB: begin mul_a = bw_r; mul_b = bd_r; end
      S_P1: begin
        mul_a = an_r;
        mul_b = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      S_P2: begin
        mul_a = (op_r == OP_DIV) ? ad_r : bn_r;
        mul_b = (op_r == OP_DIV) ? bn_r : ad_r;
      end
      S_P3: begin mul_a = ad_r; mul_b = bd_r; end
      S_QMUL: begin mul_a = q_r; mul_b = d_r; end
      S_QDIV: begin div_go = !dbusy_r; div_num = n_r; div_den = d_r; end
      // The Euclid loop ends once the remainder is zero; no divide starts then.
      S_GDIV: begin
        div_go = !dbusy_r && (x_r != '0);
        div_num = p_r;
        div_den = x_r;
      end
      S_RN: begin div_go = !dbusy_r; div_num = n_r; div_den = x_r; end
      S_RD: begin div_go = !dbusy_r; div_num = d_r; div_den = x_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r <= '0;
    end else if (div_go) begin
      dbusy_r <= 1'b1;
      dcnt_r <= CW'(W);
      dq_r <= wabs(div_num);
      drem_r <= '0;
      dd_r <= wabs(div_den);
      dnq_r <= div_num[W-1] ^ div_den[W-1];
      dnr_r <= div_num[W-1];
    end else if (dbusy_r) begin
      if (dcnt_r == '0) begin
        dbusy_r <= 1'b0;
      end else begin
        dcnt_r <= dcnt_r - 1'b1;
        if (!dtrial[W]) begin
          drem_r <= dtrial[W-1:0];
          dq_r <= {dq_r[W-2:0], 1'b1};
        end else begin
          drem_r <= {drem_r[W-2:0], dq_r[W-1]};
          dq_r <= {dq_r[W-2:0], 1'b0};
        end
      end
    end
  end

  // Magnitudes are compared as signed values; the most negative word keeps a
  // negative "magnitude" and so compares below every other value.
  logic n_gt_d;
  assign n_gt_d = $signed(wabs(n_r)) > $signed(wabs(d_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // A new result is loaded only when the output register is free or
      // being emptied in this same cycle.
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid) begin
          op_r <= in_data.req_type;
          aw_r <= W'(in_data.a_whole);
          an_r <= W'(in_data.a_numerator);
          ad_r <= W'(in_data.a_denominator);
          bw_r <= W'(in_data.b_whole);
          bn_r <= W'(in_data.b_numerator);
          bd_r <= W'(in_data.b_denominator);
          state_r <= S_TA;
        end
        S_TA: begin
          an_r <= mul_p[W-1] ? -(an_r + wabs(mul_p)) : an_r + wabs(mul_p);
          state_r <= S_TB;
        end
        S_TB: begin
          bn_r <= mul_p[W-1] ? -(bn_r + wabs(mul_p)) : bn_r + wabs(mul_p);
          state_r <= S_IA;
        end
        S_IA: begin
          w_r <= '0;
          if ((op_r == OP_ADD || op_r == OP_SUB) && ad_r == bd_r) begin
            n_r <= (op_r == OP_ADD) ? an_r + bn_r : an_r - bn_r;
            d_r <= ad_r;
            state_r <= S_CHK;
          end else begin
            state_r <= S_P1;
          end
        end
        S_P1: begin x_r <= mul_p; state_r <= S_P2; end
        S_P2: begin
          if (op_r == OP_ADD) n_r <= x_r + mul_p;
          else if (op_r == OP_SUB) n_r <= x_r - mul_p;
          else n_r <= x_r;
          if (op_r == OP_DIV) begin
            d_r <= mul_p;
            state_r <= S_CHK;
          end else begin
            state_r <= S_P3;
          end
        end
        S_P3: begin d_r <= mul_p; state_r <= S_CHK; end
        S_CHK: begin
          if (d_r == '0) begin
            // The whole part is already zero; the denominator flags the case.
            n_r <= '0;
            state_r <= S_OUT;
          end else if (n_gt_d) begin
            state_r <= S_QDIV;
          end else begin
            state_r <= S_FIX;
          end
        end
        S_QDIV: if (ddone) begin
          q_r <= quo;
          state_r <= S_QMUL;
        end
        S_QMUL: begin
          w_r <= w_r + q_r;
          n_r <= n_r - mul_p;
          state_r <= S_FIX;
        end
        S_FIX: begin
          if (d_r == n_r) begin
            n_r <= '0;
            w_r <= w_r + 1'b1;
            state_r <= S_RDD;
          end else if (n_r == '0) begin
            state_r <= S_RDD;
          end else begin
            state_r <= S_GSTART;
          end
        end
        S_GSTART: begin p_r <= n_r; x_r <= d_r; state_r <= S_GDIV; end
        S_GDIV: begin
          if (x_r == '0) begin
            x_r <= wabs(p_r);
            state_r <= S_GNEXT;
          end else if (ddone) begin
            p_r <= x_r;
            x_r <= (x_r == '1) ? '0 : rem;
          end
        end
        S_GNEXT: begin
          if (x_r == W'(1) || x_r == '0) state_r <= S_RDD;
          else state_r <= S_RN;
        end
        S_RN: if (ddone) begin
          n_r <= (x_r == '1) ? -n_r : quo;
          state_r <= S_RND;
        end
        S_RND: state_r <= S_RD;
        S_RD: if (ddone) begin
          d_r <= (x_r == '1) ? -d_r : quo;
          state_r <= S_RDD;
        end
        S_RDD: state_r <= S_OUT;
        // A reduced denominator is never zero, so a zero one marks the
        // zero-denominator result.
        S_OUT: if (!out_valid_r || !out_stall) begin
          out_r <= '{res_whole: 32'(w_r), res_numerator: 32'(n_r),
                     res_denominator: 32'(d_r), zero_denominator: (d_r == '0)};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef ASSERT_OFF
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input accepted while busy");
  a_zero_flag_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_denominator) |-> (out_data.res_denominator == '0))
    else $error("zero denominator with nonzero fields");
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_go |-> !dbusy_r)
    else $error("divider restarted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");
`endif

endmodule
